[rtl/selective_repeat_receive_window_macros.svh]
// assertion macros for the receive window checker
`ifndef SELECTIVE_REPEAT_RECEIVE_WINDOW_MACROS_SVH
`define SELECTIVE_REPEAT_RECEIVE_WINDOW_MACROS_SVH

// same-cycle implication, sampled on clock, off during reset
`define SRRW_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off during reset
`define SRRW_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/srrw_pkg.sv]
`timescale 1ns / 1ps
package srrw_pkg;

   localparam int SLOTS        = 31;
   localparam int WINDOW       = 5;
   localparam int PACKET_BYTES = 1024;

   localparam int SEQ_W    = 16;
   localparam int HANDLE_W = 32;
   localparam int LEN_W    = 10;
   localparam int HEAD_W   = 24;
   localparam int KIND_W   = 2;

   localparam int SLOT_W = $clog2(SLOTS);
   localparam int BLK_W  = SEQ_W - $clog2(PACKET_BYTES);
   localparam int CNT_W  = $clog2(WINDOW + 1);
   localparam int QDEPTH = 2;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   localparam logic [HEAD_W-1:0] FIN_WORD = 24'h46494E;

   localparam logic [KIND_W-1:0] KIND_ACK = 2'd0;
   localparam logic [KIND_W-1:0] KIND_REL = 2'd1;
   localparam logic [KIND_W-1:0] KIND_FIN = 2'd2;

   typedef struct packed {
      logic                is_fin;
      logic [SEQ_W-1:0]    seq;
      logic [HANDLE_W-1:0] handle;
      logic [LEN_W-1:0]    len;
      logic [SLOT_W-1:0]   slot;
   } srrw_desc_type;

   typedef struct packed {
      logic full;
      logic empty;
   } srrw_qstat_type;

   // block number mod SLOTS by restoring compare and subtract
   function automatic logic [SLOT_W-1:0] slot_of(input logic [SEQ_W-1:0] seq);
      logic [BLK_W-1:0] r;
      r = seq[SEQ_W-1 -: BLK_W];
      for (int k = BLK_W - 1; k >= 0; k--) begin
         if (32'(r) >= (SLOTS << k)) begin
            r = r - BLK_W'(SLOTS << k);
         end
      end
      return SLOT_W'(r);
   endfunction

   function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
      return (s == SLOT_W'(SLOTS - 1)) ? '0 : s + SLOT_W'(1);
   endfunction

endpackage

[rtl/srrw_queue.sv]
`timescale 1ns / 1ps
module srrw_queue import srrw_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  srrw_desc_type  push_data,
   input  logic           pop,
   output srrw_desc_type  pop_data,
   output srrw_qstat_type status
);

   srrw_desc_type     entry_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_push, do_pop;

   assign status.full  = (count_ff == QCNT_W'(QDEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push  = push && !status.full;
   assign do_pop   = pop && !status.empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[rtl/srrw_front.sv]
`timescale 1ns / 1ps
module srrw_front import srrw_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [SEQ_W-1:0]    req_seq_value,
   input  logic [HANDLE_W-1:0] req_payload_handle,
   input  logic [LEN_W-1:0]    req_payload_len,
   input  logic [HEAD_W-1:0]   req_head_bytes,
   input  srrw_qstat_type      q_status,
   output logic                push,
   output srrw_desc_type       push_data
);

   logic started_ff, started_in;
   logic finished_ff, finished_in;
   logic accept, is_fin;

   assign req_stall = q_status.full;
   assign accept    = req_valid && !req_stall;
   // the opening word is never taken as a finish
   assign is_fin    = started_ff && (req_head_bytes == FIN_WORD);
   // after a finish every word is swallowed
   assign push      = accept && !finished_ff;

   assign push_data.is_fin = is_fin;
   assign push_data.seq    = req_seq_value;
   assign push_data.handle = req_payload_handle;
   assign push_data.len    = req_payload_len;
   assign push_data.slot   = slot_of(req_seq_value);

   always_comb begin
      started_in  = started_ff;
      finished_in = finished_ff;
      if (push) begin
         started_in = 1'b1;
         if (is_fin) begin
            finished_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff  <= 1'b0;
         finished_ff <= 1'b0;
      end else begin
         started_ff  <= started_in;
         finished_ff <= finished_in;
      end
   end

endmodule

[rtl/srrw_back.sv]
`timescale 1ns / 1ps
module srrw_back import srrw_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  srrw_qstat_type      q_status,
   input  srrw_desc_type       q_data,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [KIND_W-1:0]   rsp_kind,
   output logic [SEQ_W-1:0]    rsp_ack_seq,
   output logic [HANDLE_W-1:0] rsp_out_handle,
   output logic [LEN_W-1:0]    rsp_out_len,
   output logic                rsp_last
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_REL  = 1'b1;

   logic                state_ff, state_in;
   logic [SLOT_W-1:0]   expected_ff, expected_in;
   logic [SLOT_W-1:0]   idx_ff, idx_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [SLOTS-1:0]    pending_ff;
   logic [HANDLE_W-1:0] store_handle [SLOTS];
   logic [LEN_W-1:0]    store_len [SLOTS];

   logic                valid_ff, valid_in;
   logic [KIND_W-1:0]   kind_ff, kind_in;
   logic [SEQ_W-1:0]    seq_ff, seq_in;
   logic [HANDLE_W-1:0] handle_ff, handle_in;
   logic [LEN_W-1:0]    len_ff, len_in;
   logic                last_ff, last_in;

   logic              out_free, wr_en, pend_set, pend_clr;
   logic [SLOT_W-1:0] nxt;
   logic [CNT_W-1:0]  cnt_nx;

   assign out_free = !valid_ff || !rsp_stall;
   assign nxt      = next_slot(idx_ff);
   assign cnt_nx   = cnt_ff + CNT_W'(1);

   always_comb begin
      state_in    = state_ff;
      expected_in = expected_ff;
      idx_in      = idx_ff;
      cnt_in      = cnt_ff;
      valid_in    = valid_ff && rsp_stall;
      kind_in     = kind_ff;
      seq_in      = seq_ff;
      handle_in   = handle_ff;
      len_in      = len_ff;
      last_in     = last_ff;
      pop         = 1'b0;
      wr_en       = 1'b0;
      pend_set    = 1'b0;
      pend_clr    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (!q_status.empty && out_free) begin
               pop       = 1'b1;
               valid_in  = 1'b1;
               seq_in    = '0;
               handle_in = '0;
               len_in    = '0;
               if (q_data.is_fin) begin
                  kind_in = KIND_FIN;
                  last_in = 1'b1;
               end else begin
                  kind_in = KIND_ACK;
                  seq_in  = q_data.seq;
                  wr_en   = 1'b1;
                  if (q_data.slot == expected_ff) begin
                     last_in  = 1'b0;
                     state_in = ST_REL;
                     idx_in   = q_data.slot;
                     cnt_in   = '0;
                  end else begin
                     last_in  = 1'b1;
                     pend_set = 1'b1;
                  end
               end
            end
         end
         ST_REL: begin
            // first pass releases the packet just stored, then the buffered run
            if (out_free) begin
               valid_in  = 1'b1;
               kind_in   = KIND_REL;
               seq_in    = '0;
               handle_in = store_handle[idx_ff];
               len_in    = store_len[idx_ff];
               pend_clr  = 1'b1;
               cnt_in    = cnt_nx;
               idx_in    = nxt;
               if (cnt_nx == CNT_W'(WINDOW) || !pending_ff[nxt]) begin
                  last_in     = 1'b1;
                  expected_in = nxt;
                  state_in    = ST_IDLE;
               end else begin
                  last_in = 1'b0;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         expected_ff <= '0;
         idx_ff      <= '0;
         cnt_ff      <= '0;
         valid_ff    <= 1'b0;
         pending_ff  <= '0;
      end else begin
         state_ff    <= state_in;
         expected_ff <= expected_in;
         idx_ff      <= idx_in;
         cnt_ff      <= cnt_in;
         valid_ff    <= valid_in;
         if (pend_set) begin
            pending_ff[q_data.slot] <= 1'b1;
         end
         if (pend_clr) begin
            pending_ff[idx_ff] <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      kind_ff   <= kind_in;
      seq_ff    <= seq_in;
      handle_ff <= handle_in;
      len_ff    <= len_in;
      last_ff   <= last_in;
      if (wr_en) begin
         store_handle[q_data.slot] <= q_data.handle;
         store_len[q_data.slot]    <= q_data.len;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_kind       = kind_ff;
   assign rsp_ack_seq    = seq_ff;
   assign rsp_out_handle = handle_ff;
   assign rsp_out_len    = len_ff;
   assign rsp_last       = last_ff;

endmodule

[rtl/selective_repeat_receive_window.sv]
`timescale 1ns / 1ps
// channel  direction  handshake              word
// req_     in         req_valid / req_stall  seq_value, payload_handle, payload_len, head_bytes
// rsp_     out        rsp_valid / rsp_stall  kind, ack_seq, out_handle, out_len, last
//
// a packet that does not hit the expected slot, and a finish, each give one word from ST_IDLE
// an expected-slot packet is acked, then ST_REL releases it and n buffered slots (n < WINDOW)
// the back end emits one word per cycle unless rsp_ stalls; the output register sets that pace
// reset is synchronous and clears the flags, the queue, the expected slot and all pending bits
// a two-word queue between front and back lets req_ flow while rsp_ stalls, until it fills
module selective_repeat_receive_window import srrw_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [SEQ_W-1:0]    req_seq_value,
   input  logic [HANDLE_W-1:0] req_payload_handle,
   input  logic [LEN_W-1:0]    req_payload_len,
   input  logic [HEAD_W-1:0]   req_head_bytes,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [KIND_W-1:0]   rsp_kind,
   output logic [SEQ_W-1:0]    rsp_ack_seq,
   output logic [HANDLE_W-1:0] rsp_out_handle,
   output logic [LEN_W-1:0]    rsp_out_len,
   output logic                rsp_last
);

   srrw_qstat_type q_status;
   srrw_desc_type  push_data, pop_data;
   logic           push, pop;

   srrw_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_seq_value      (req_seq_value),
      .req_payload_handle (req_payload_handle),
      .req_payload_len    (req_payload_len),
      .req_head_bytes     (req_head_bytes),
      .q_status           (q_status),
      .push               (push),
      .push_data          (push_data)
   );

   srrw_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .status    (q_status)
   );

   srrw_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_status       (q_status),
      .q_data         (pop_data),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_kind       (rsp_kind),
      .rsp_ack_seq    (rsp_ack_seq),
      .rsp_out_handle (rsp_out_handle),
      .rsp_out_len    (rsp_out_len),
      .rsp_last       (rsp_last)
   );

endmodule

[rtl/srrw_checker.sv]
`timescale 1ns / 1ps
`include "selective_repeat_receive_window_macros.svh"
module srrw_checker import srrw_pkg::*; (
   input logic                clock,
   input logic                reset,
   input logic                rsp_valid,
   input logic                rsp_stall,
   input logic [KIND_W-1:0]   rsp_kind,
   input logic [SEQ_W-1:0]    rsp_ack_seq,
   input logic [HANDLE_W-1:0] rsp_out_handle,
   input logic [LEN_W-1:0]    rsp_out_len,
   input logic                rsp_last
);

   `SRRW_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall,
      rsp_valid && $stable({rsp_kind, rsp_ack_seq, rsp_out_handle, rsp_out_len, rsp_last}),
      "stalled rsp word changed")
   `SRRW_ASSERT_NOW(a_fin_last, rsp_valid && (rsp_kind == KIND_FIN),
      rsp_last && (rsp_ack_seq == '0) && (rsp_out_handle == '0), "finish word malformed")
   `SRRW_ASSERT_NEXT(a_quiet_after_fin, rsp_valid && !rsp_stall && (rsp_kind == KIND_FIN),
      !rsp_valid, "word after finish")
   `SRRW_ASSERT_NOW(a_ack_clean, rsp_valid && (rsp_kind == KIND_ACK),
      (rsp_out_handle == '0) && (rsp_out_len == '0), "ack word carries payload")

endmodule

bind selective_repeat_receive_window srrw_checker u_srrw_checker (.*);

[test/selective_repeat_receive_window_check.sv]
`timescale 1ns / 1ps
module selective_repeat_receive_window_check import srrw_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_stall,
   input  logic [SEQ_W-1:0]    req_seq_value,
   input  logic [HANDLE_W-1:0] req_payload_handle,
   input  logic [LEN_W-1:0]    req_payload_len,
   input  logic [HEAD_W-1:0]   req_head_bytes,
   input  logic                rsp_valid,
   input  logic                rsp_stall,
   input  logic [KIND_W-1:0]   rsp_kind,
   input  logic [SEQ_W-1:0]    rsp_ack_seq,
   input  logic [HANDLE_W-1:0] rsp_out_handle,
   input  logic [LEN_W-1:0]    rsp_out_len,
   input  logic                rsp_last,
   output int                  fail_count,
   output int                  words_waiting,
   output logic [SLOT_W-1:0]   wanted_slot
);

   typedef struct packed {
      logic [KIND_W-1:0]   kind;
      logic [SEQ_W-1:0]    ack_seq;
      logic [HANDLE_W-1:0] handle;
      logic [LEN_W-1:0]    len;
      logic                last;
   } rsp_word_type;

   rsp_word_type        due_words[$];
   logic                opened;
   logic                closed;
   logic [SLOT_W-1:0]   window_head;
   logic                held[SLOTS];
   logic [HANDLE_W-1:0] held_handle[SLOTS];
   logic [LEN_W-1:0]    held_len[SLOTS];

   function automatic logic [SLOT_W-1:0] step_slot(input logic [SLOT_W-1:0] s);
      return (int'(s) == SLOTS - 1) ? '0 : s + 1'b1;
   endfunction

   function automatic rsp_word_type make_word(input logic [KIND_W-1:0] kind,
                                              input logic [SEQ_W-1:0] seq,
                                              input logic [HANDLE_W-1:0] handle,
                                              input logic [LEN_W-1:0] len,
                                              input logic last);
      rsp_word_type w;
      w.kind    = kind;
      w.ack_seq = seq;
      w.handle  = handle;
      w.len     = len;
      w.last    = last;
      return w;
   endfunction

   // works out the words one accepted packet must produce
   task automatic absorb_packet(input logic [SEQ_W-1:0] seq,
                                input logic [HANDLE_W-1:0] handle,
                                input logic [LEN_W-1:0] len,
                                input logic [HEAD_W-1:0] head);
      logic [SLOT_W-1:0] slot;
      logic [SLOT_W-1:0] idx;
      int                chain;
      if (closed) begin
         return;
      end
      if (opened && head == FIN_WORD) begin
         closed = 1'b1;
         due_words.push_back(make_word(KIND_FIN, '0, '0, '0, 1'b1));
         return;
      end
      opened = 1'b1;
      slot = SLOT_W'((int'(seq) / PACKET_BYTES) % SLOTS);
      held_handle[slot] = handle;
      held_len[slot]    = len;
      if (slot != window_head) begin
         held[slot] = 1'b1;
         due_words.push_back(make_word(KIND_ACK, seq, '0, '0, 1'b1));
         return;
      end
      // count the buffered run that follows, capped by the window
      chain = 0;
      idx = step_slot(slot);
      while (chain < WINDOW - 1 && held[idx]) begin
         chain++;
         idx = step_slot(idx);
      end
      due_words.push_back(make_word(KIND_ACK, seq, '0, '0, 1'b0));
      due_words.push_back(make_word(KIND_REL, '0, handle, len, chain == 0));
      held[slot] = 1'b0;
      idx = step_slot(slot);
      for (int k = 1; k <= chain; k++) begin
         due_words.push_back(make_word(KIND_REL, '0, held_handle[idx], held_len[idx],
                                       k == chain));
         held[idx] = 1'b0;
         idx = step_slot(idx);
      end
      window_head = idx;
   endtask

   task automatic check_word();
      rsp_word_type w;
      if (due_words.size() == 0) begin
         $display("%0t: unexpected word kind %0d seq %h handle %h len %0d last %b",
                  $time, rsp_kind, rsp_ack_seq, rsp_out_handle, rsp_out_len, rsp_last);
         fail_count++;
         return;
      end
      w = due_words.pop_front();
      if (rsp_kind !== w.kind) begin
         $display("%0t: kind expected %0d got %0d", $time, w.kind, rsp_kind);
         fail_count++;
      end
      if (rsp_ack_seq !== w.ack_seq) begin
         $display("%0t: ack_seq expected %h got %h", $time, w.ack_seq, rsp_ack_seq);
         fail_count++;
      end
      if (rsp_out_handle !== w.handle) begin
         $display("%0t: out_handle expected %h got %h", $time, w.handle, rsp_out_handle);
         fail_count++;
      end
      if (rsp_out_len !== w.len) begin
         $display("%0t: out_len expected %0d got %0d", $time, w.len, rsp_out_len);
         fail_count++;
      end
      if (rsp_last !== w.last) begin
         $display("%0t: last expected %b got %b", $time, w.last, rsp_last);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         due_words.delete();
         opened = 1'b0;
         closed = 1'b0;
         window_head = '0;
         for (int k = 0; k < SLOTS; k++) begin
            held[k]        = 1'b0;
            held_handle[k] = '0;
            held_len[k]    = '0;
         end
      end else begin
         if (req_valid && !req_stall) begin
            absorb_packet(req_seq_value, req_payload_handle, req_payload_len, req_head_bytes);
         end
         if (rsp_valid && !rsp_stall) begin
            check_word();
         end
      end
      words_waiting = due_words.size();
      wanted_slot   = window_head;
   end

endmodule

[test/selective_repeat_receive_window_test.sv]
`timescale 1ns / 1ps
module selective_repeat_receive_window_test;
   import srrw_pkg::*;

   localparam int PHASE_WORDS = 42;
   localparam int LONG_HOLD   = 200;
   localparam int DRAIN       = 20;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic [SEQ_W-1:0]    req_seq_value;
   logic [HANDLE_W-1:0] req_payload_handle;
   logic [LEN_W-1:0]    req_payload_len;
   logic [HEAD_W-1:0]   req_head_bytes;
   logic                rsp_valid;
   logic                rsp_stall;
   logic [KIND_W-1:0]   rsp_kind;
   logic [SEQ_W-1:0]    rsp_ack_seq;
   logic [HANDLE_W-1:0] rsp_out_handle;
   logic [LEN_W-1:0]    rsp_out_len;
   logic                rsp_last;

   int                  fail_count;
   int                  words_waiting;
   logic [SLOT_W-1:0]   wanted_slot;

   int tx_idle_pct = 36;
   int rx_idle_pct = 67;
   int hold_asks   = 0;
   int holds_done  = 0;
   int sent        = 0;

   selective_repeat_receive_window u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_seq_value      (req_seq_value),
      .req_payload_handle (req_payload_handle),
      .req_payload_len    (req_payload_len),
      .req_head_bytes     (req_head_bytes),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_kind           (rsp_kind),
      .rsp_ack_seq        (rsp_ack_seq),
      .rsp_out_handle     (rsp_out_handle),
      .rsp_out_len        (rsp_out_len),
      .rsp_last           (rsp_last)
   );

   selective_repeat_receive_window_check u_check (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_seq_value      (req_seq_value),
      .req_payload_handle (req_payload_handle),
      .req_payload_len    (req_payload_len),
      .req_head_bytes     (req_head_bytes),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_kind           (rsp_kind),
      .rsp_ack_seq        (rsp_ack_seq),
      .rsp_out_handle     (rsp_out_handle),
      .rsp_out_len        (rsp_out_len),
      .rsp_last           (rsp_last),
      .fail_count         (fail_count),
      .words_waiting      (words_waiting),
      .wanted_slot        (wanted_slot)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("selective_repeat_receive_window_test NOT OK");
      $finish;
   end

   // receiver side: random stall, or one long hold-off when asked
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_asks != holds_done) begin
            holds_done++;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(negedge clock);
         end
         rsp_stall <= ($urandom_range(99) < rx_idle_pct);
      end
   end

   task automatic offer(input logic [SEQ_W-1:0] seq, input logic [HANDLE_W-1:0] handle,
                        input logic [LEN_W-1:0] len, input logic [HEAD_W-1:0] head);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid          <= 1'b1;
      req_seq_value      <= seq;
      req_payload_handle <= handle;
      req_payload_len    <= len;
      req_head_bytes     <= head;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      sent++;
   endtask

   function automatic logic [LEN_W-1:0] pick_len();
      case ($urandom_range(9))
         0:       return '0;
         1:       return LEN_W'(1022);
         default: return LEN_W'($urandom_range(1022));
      endcase
   endfunction

   // random head bytes that never spell the finish marker
   function automatic logic [HEAD_W-1:0] pick_head();
      logic [HEAD_W-1:0] h;
      if ($urandom_range(7) == 0) begin
         h = {FIN_WORD[HEAD_W-1:8], 8'($urandom)};
      end else begin
         h = HEAD_W'($urandom);
      end
      if (h == FIN_WORD) begin
         h[0] = ~h[0];
      end
      return h;
   endfunction

   // one packet landing on a given slot, through any block number that maps there
   task automatic send_slot(input int slot);
      int blk;
      blk = slot + SLOTS * $urandom_range(0, (slot <= 1) ? 2 : 1);
      offer({6'(blk), 10'($urandom)}, HANDLE_W'($urandom), pick_len(), pick_head());
   endtask

   // a run of slots ahead of the window head in shuffled order, then the head
   task automatic send_burst();
      int n;
      int base;
      int j;
      int t;
      int order[WINDOW + 1];
      n = $urandom_range(1, WINDOW + 1);
      base = int'(wanted_slot);
      for (int k = 0; k < n - 1; k++) begin
         order[k] = k + 1;
      end
      for (int k = n - 2; k > 0; k--) begin
         j = $urandom_range(0, k);
         t = order[k];
         order[k] = order[j];
         order[j] = t;
      end
      for (int k = 0; k < n - 1; k++) begin
         send_slot((base + order[k]) % SLOTS);
         if ($urandom_range(9) == 0) begin
            send_slot((base + order[k]) % SLOTS);
         end
      end
      send_slot(base);
   endtask

   initial begin
      int mark;
      reset              = 1'b1;
      req_valid          = 1'b0;
      req_seq_value      = '0;
      req_payload_handle = '0;
      req_payload_len    = '0;
      req_head_bytes     = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // opening packet spells the finish marker but must be taken as data
      offer(16'h0000, 32'h0000_0000, 10'd0, FIN_WORD);
      offer(16'hFFFF, 32'hFFFF_FFFF, 10'd1022, 24'hFFFFFF);
      offer(SEQ_W'(3 * PACKET_BYTES), 32'h0000_0003, 10'd3, 24'h464900);
      offer(SEQ_W'(35 * PACKET_BYTES), 32'h0000_0004, 10'd4, 24'h46494F);
      offer(SEQ_W'(5 * PACKET_BYTES + 17), 32'h0000_0005, 10'd5, 24'h000000);
      offer(SEQ_W'(6 * PACKET_BYTES), 32'h0000_0006, 10'd6, 24'h4E4946);
      offer(SEQ_W'(7 * PACKET_BYTES), 32'h0000_0007, 10'd7, 24'h123456);
      // same buffered slot twice: the second copy wins
      offer(SEQ_W'(9 * PACKET_BYTES), 32'hAAAA_0009, 10'd100, 24'h555555);
      offer(SEQ_W'(40 * PACKET_BYTES), 32'hBBBB_0009, 10'd200, 24'hAAAAAA);
      // head of window releases four buffered slots and stops at the window edge
      offer(SEQ_W'(2 * PACKET_BYTES + 1023), 32'h0000_0002, 10'd2, 24'h464A4E);
      // duplicate of a slot already released is parked again
      offer(SEQ_W'(62 * PACKET_BYTES), 32'hDEAD_0000, 10'd512, 24'h0F0F0F);
      offer(SEQ_W'(7 * PACKET_BYTES + 5), 32'h7777_7777, 10'd777, 24'hF0F0F0);
      offer(SEQ_W'(8 * PACKET_BYTES), 32'h0000_0008, 10'd1022, 24'h454850);
      offer(16'h03FF, 32'h8000_0001, 10'd1, 24'h800000);
      offer(SEQ_W'(10 * PACKET_BYTES), 32'h0000_0000, 10'd0, 24'h000000);

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               tx_idle_pct = 36;
               rx_idle_pct = 67;
            end
            1: begin
               tx_idle_pct = 67;
               rx_idle_pct = 36;
            end
            default: begin
               tx_idle_pct = 0;
               rx_idle_pct = 0;
               hold_asks++;
            end
         endcase
         mark = sent;
         while (sent - mark < PHASE_WORDS) begin
            if ($urandom_range(9) < 7) begin
               send_burst();
            end else begin
               offer(SEQ_W'($urandom), HANDLE_W'($urandom), pick_len(), pick_head());
            end
         end
      end

      // finish, then everything after it is dropped
      offer(SEQ_W'($urandom), HANDLE_W'($urandom), pick_len(), FIN_WORD);
      offer(SEQ_W'($urandom), HANDLE_W'($urandom), pick_len(), pick_head());
      offer(SEQ_W'(int'(wanted_slot) * PACKET_BYTES), 32'h1234_5678, 10'd9, 24'h000001);
      offer(SEQ_W'($urandom), HANDLE_W'($urandom), pick_len(), FIN_WORD);
      req_valid <= 1'b0;

      wait (words_waiting == 0);
      repeat (DRAIN) @(posedge clock);
      if (fail_count == 0 && words_waiting == 0) begin
         $display("selective_repeat_receive_window_test OK");
      end else begin
         $display("selective_repeat_receive_window_test NOT OK");
      end
      $finish;
   end

endmodule
